// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the deque datapath.
// Both macros expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after the trigger.
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg)
`endif
`endif

// ===== design/cbd_pkg.sv =====
// ---------------------------------------------------------------------------
// cbd_pkg
// Types, operation codes and status codes of the ring buffer deque.
// ---------------------------------------------------------------------------
package cbd_pkg;

    // Default number of store entries.
    localparam int DEPTH_DEFAULT = 1024;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int VAL_W    = 31;
    localparam int POP_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Value returned when nothing is popped.
    localparam logic signed [POP_W-1:0] NEG_ONE = '1;

    // One request.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] push_value;
    } req_t;

    // One response.
    typedef struct packed {
        logic signed [POP_W-1:0] popped_value;
        logic [STATUS_W-1:0]     status;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rsp_free;
    } dp_stat_t;

endpackage

// ===== design/circular_buffer_deque_top.sv =====
// ---------------------------------------------------------------------------
// circular_buffer_deque_top
// Double-ended queue in a fixed ring store with push and pop at both ends.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   cbd_pkg::req_t (op, push_value)
//   rsp      out        rsp_valid/rsp_stall   cbd_pkg::rsp_t (popped_value, status,
//                                             occupancy)
//
// Each request goes through accept, execute (pointer update and one
// access to the single-port entry store, whose read data is registered), and
// load of the response register. A response may wait in that register while
// the next request is accepted and executed. Reset clears pointers, count
// and response valid; the store is not cleared, since no entry is read before
// it is written. A stalled response holds the next request in its load step.
//
module circular_buffer_deque_top #(
    parameter int DEPTH = cbd_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cbd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cbd_pkg::rsp_t rsp
);
    import cbd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    cbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store, pointers and response register.
    cbd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== design/cbd_ctrl.sv =====
// ---------------------------------------------------------------------------
// cbd_ctrl
// Sequencer that takes one request at a time through execute and result load.
// ---------------------------------------------------------------------------
module cbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cbd_pkg::dp_stat_t stat,
    output cbd_pkg::dp_cmd_t  cmd
);
    import cbd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    // Next state and next stall.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    // State and registered stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    // Commands to the datapath.
    assign req_stall   = stall_reg;
    assign cmd.capture = req_valid && !stall_reg;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.load    = (state_reg == S_RESULT) && stat.rsp_free;

endmodule

// ===== design/cbd_datapath.sv =====
// ---------------------------------------------------------------------------
// cbd_datapath
// Entry store, front and back pointers, entry count and response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_datapath #(
    parameter int DEPTH = cbd_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cbd_pkg::req_t     req,
    input  cbd_pkg::dp_cmd_t  cmd,
    output cbd_pkg::dp_stat_t stat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cbd_pkg::rsp_t     rsp
);
    import cbd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Wrapping pointer steps for any depth.
    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - IDX_W'(1);
    endfunction

    logic [VAL_W-1:0]    mem [DEPTH];
    req_t                req_reg;
    logic [IDX_W-1:0]    front_reg;
    logic [IDX_W-1:0]    front_next;
    logic [IDX_W-1:0]    back_reg;
    logic [IDX_W-1:0]    back_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                pop_ok_reg;
    logic                pop_ok_next;
    logic [VAL_W-1:0]    rd_data_reg;
    rsp_t                rsp_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                is_full;
    logic                is_empty;
    logic                is_push;
    logic                wr_en;
    logic                rd_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;

    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign is_push  = (req_reg.op == OP_PUSH_FRONT) || (req_reg.op == OP_PUSH_BACK);

    // Decode of the held request against the current pointers.
    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_reg;
        rd_addr     = front_reg;
        unique case (req_reg.op)
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_next = step_down(front_reg);
                    wr_addr    = front_next;
                    wr_en      = cmd.exec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_addr     = front_reg;
                    rd_en       = cmd.exec;
                    pop_ok_next = 1'b1;
                    front_next  = step_up(front_reg);
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_addr    = back_reg;
                    wr_en      = cmd.exec;
                    back_next  = step_up(back_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    back_next   = step_down(back_reg);
                    rd_addr     = back_next;
                    rd_en       = cmd.exec;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Entry store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_reg.push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request, result flags and response payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (cmd.load)
        begin
            rsp_reg.popped_value <= pop_ok_reg ? $signed({1'b0, rd_data_reg}) : NEG_ONE;
            rsp_reg.status       <= status_reg;
            rsp_reg.occupancy    <= OCC_W'(count_reg);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Response valid: set on load, cleared once taken.
    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign stat.rsp_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

    // The count never passes the depth, and an empty or full ring has meeting pointers.
    `CBD_ASSERT(a_count_range, clk, rst_n, count_reg <= CNT_FULL, "entry count above depth")
    `CBD_ASSERT(a_ptr_meet, clk, rst_n, !(is_empty || is_full) || (front_reg == back_reg), "pointers do not meet")
    // A response is never loaded over one that is still stalled.
    `CBD_ASSERT(a_no_overwrite, clk, rst_n, !(cmd.load && rsp_valid_reg && rsp_stall), "response overwritten")
    // An accepted push on a deque that is not full adds exactly one entry.
    `CBD_ASSERT_NEXT(a_push_count, clk, rst_n, cmd.exec && is_push && !is_full, count_reg == $past(count_reg) + CNT_W'(1), "push did not add one entry")

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Checks the ring buffer deque against a cycle-free model of its contents.
// Each accepted request is applied to the model. The model records the
// response it implies, and every response taken from the block must match
// the oldest one still outstanding. The stimulus covers empty pops, the
// pointer wrap at both ends, a push-heavy climb to a high fill level and a
// drain back through empty. Both channels idle at random, and the receiver
// holds off for long stretches to back up the request channel.
// ---------------------------------------------------------------------------
module testbench;
    import cbd_pkg::*;

    localparam int DEQUE_DEPTH = cbd_pkg::DEPTH_DEFAULT;

    // Model of the deque contents and the queue of responses still owed.
    class deque_scoreboard;
        logic [VAL_W-1:0] slots [DEQUE_DEPTH];
        int               front_idx;
        int               back_idx;
        int               held_n;
        int               errors;
        rsp_t             owed_rsps [$];

        function new();
            front_idx = 0;
            back_idx  = 0;
            held_n    = 0;
            errors    = 0;
        endfunction

        function int held();
            return held_n;
        endfunction

        function int owed();
            return owed_rsps.size();
        endfunction

        // Apply one accepted request and record the response it implies.
        function void note_request(req_t r);
            rsp_t want;
            want.popped_value = NEG_ONE;
            want.status       = ST_DONE;
            case (r.op)
                OP_PUSH_FRONT:
                begin
                    if (held_n >= DEQUE_DEPTH)
                    begin
                        want.status = ST_FULL;
                    end
                    else
                    begin
                        front_idx = (front_idx + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
                        slots[front_idx] = r.push_value;
                        held_n++;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (held_n == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        want.popped_value = $signed({1'b0, slots[front_idx]});
                        front_idx = (front_idx + 1) % DEQUE_DEPTH;
                        held_n--;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (held_n >= DEQUE_DEPTH)
                    begin
                        want.status = ST_FULL;
                    end
                    else
                    begin
                        slots[back_idx] = r.push_value;
                        back_idx = (back_idx + 1) % DEQUE_DEPTH;
                        held_n++;
                    end
                end
                default:
                begin
                    if (held_n == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        back_idx = (back_idx + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
                        want.popped_value = $signed({1'b0, slots[back_idx]});
                        held_n--;
                    end
                end
            endcase
            want.occupancy = OCC_W'(held_n);
            owed_rsps = {owed_rsps, want};
        endfunction

        // Compare one accepted response with the oldest owed one.
        function void check_response(rsp_t got);
            rsp_t want;
            if (owed_rsps.size() == 0)
            begin
                $display("%0t: unexpected response: popped_value %0d status %0d occupancy %0d",
                         $time, got.popped_value, got.status, got.occupancy);
                errors++;
                return;
            end
            want = owed_rsps[0];
            owed_rsps.delete(0);
            if (got.popped_value !== want.popped_value)
            begin
                $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                         $time, want.popped_value, got.popped_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    req_t            req;
    logic            rsp_valid;
    logic            rsp_stall;
    rsp_t            rsp;

    deque_scoreboard sb;
    bit              calm;
    int              sent_n;

    circular_buffer_deque_top #(
        .DEPTH(DEQUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Random request with the given percentage of pushes.
    function automatic req_t make_request(int push_pct);
        req_t r;
        if ($urandom_range(0, 99) < push_pct)
        begin
            r.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        else
        begin
            r.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        case ($urandom_range(0, 9))
            0:       r.push_value = '1;
            1:       r.push_value = '0;
            default: r.push_value = VAL_W'($urandom);
        endcase
        return r;
    endfunction

    // Offer one request after a random gap and wait until it is accepted.
    task automatic send_request(input req_t r);
        int gap;
        // Switch between idling and back-to-back traffic now and then.
        if (sent_n % 64 == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
        end
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        sb.note_request(r);
        sent_n++;
    endtask

    // Response side: random stalls, long hold-offs, check every response.
    initial
    begin
        int hold;
        int taken_n;
        rsp_stall = 1'b0;
        taken_n   = 0;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 4);
            if (taken_n == 150 || taken_n == 600)
            begin
                hold = 60;
            end
            if (hold > 0)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_valid && !rsp_stall));
            sb.check_response(rsp);
            taken_n++;
        end
    end

    // Main sequence.
    initial
    begin
        sb        = new();
        calm      = 1'b0;
        sent_n    = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pops, wrap at both ends, bit patterns.
        send_request(req_t'{OP_POP_FRONT,  VAL_W'(0)});
        send_request(req_t'{OP_POP_BACK,   {VAL_W{1'b1}}});
        send_request(req_t'{OP_PUSH_FRONT, {VAL_W{1'b1}}});
        send_request(req_t'{OP_POP_BACK,   VAL_W'(0)});
        send_request(req_t'{OP_PUSH_BACK,  VAL_W'(0)});
        send_request(req_t'{OP_PUSH_FRONT, VAL_W'(32'h2AAA_AAAA)});
        send_request(req_t'{OP_PUSH_BACK,  VAL_W'(32'h5555_5555)});
        send_request(req_t'{OP_POP_FRONT,  VAL_W'(0)});
        send_request(req_t'{OP_POP_FRONT,  VAL_W'(0)});
        send_request(req_t'{OP_POP_FRONT,  VAL_W'(0)});
        send_request(req_t'{OP_POP_FRONT,  VAL_W'(0)});
        send_request(req_t'{OP_PUSH_BACK,  VAL_W'(1)});
        send_request(req_t'{OP_POP_BACK,   VAL_W'(0)});
        send_request(req_t'{OP_POP_BACK,   VAL_W'(0)});
        send_request(req_t'{OP_PUSH_FRONT, VAL_W'(32'h4000_0000)});
        send_request(req_t'{OP_PUSH_FRONT, VAL_W'(1)});
        send_request(req_t'{OP_POP_BACK,   VAL_W'(0)});
        send_request(req_t'{OP_POP_BACK,   VAL_W'(0)});

        // Random mix around a small fill level.
        repeat (250) send_request(make_request(55));

        // Push-heavy climb to a high fill level.
        repeat (200) send_request(make_request(85));

        // Pop-heavy drain through empty, with pops on the empty deque.
        repeat (260) send_request(make_request(15));

        // Final random mix.
        repeat (30) send_request(make_request(50));

        @(negedge clk);
        req_valid <= 1'b0;

        // Wait for every owed response, then for any stray ones.
        while (sb.owed() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/cbd_pkg.sv
design/cbd_ctrl.sv
design/cbd_datapath.sv
design/circular_buffer_deque_top.sv
sim/testbench.sv
